// ===== design/utf16_to_utf8_transcoder_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the transcoder RTL
// ---------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_TOP_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, idle in reset
`define UTT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/utt_pkg.sv =====
// ---------------------------------------------------------------------------
// utt_pkg
// Types, constants and the byte encoder shared by the transcoder modules.
// ---------------------------------------------------------------------------
package utt_pkg;

	localparam int CP_W = 21;

	localparam logic [5:0]      HIGH_PREFIX    = 6'b110110;  // D800..DBFF
	localparam logic [5:0]      LOW_PREFIX     = 6'b110111;  // DC00..DFFF
	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
	localparam logic [CP_W-1:0] SUPP_BASE      = 21'h010000;
	localparam logic [CP_W-1:0] MAX_ONE_BYTE   = 21'h00007F;
	localparam logic [CP_W-1:0] MAX_TWO_BYTE   = 21'h0007FF;
	localparam logic [CP_W-1:0] MAX_THREE_BYTE = 21'h00FFFF;
	localparam logic [2:0]      REPL_LEN       = 3'd3;

	// one job per transfer that produces output
	typedef struct packed {
		logic            pre_fffd;  // replacement for an unpaired held high surrogate
		logic            cp_valid;
		logic [CP_W-1:0] cp;
		logic [2:0]      nb;        // encoded length of cp, 1..4
	} job_t;

	function automatic logic [2:0] utt_len(input logic [CP_W-1:0] cp);
		logic [2:0] n;
		if (cp <= MAX_ONE_BYTE) begin
			n = 3'd1;
		end else if (cp <= MAX_TWO_BYTE) begin
			n = 3'd2;
		end else if (cp <= MAX_THREE_BYTE) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	// byte k of the nb-byte encoding of cp
	function automatic logic [7:0] utt_byte(input logic [CP_W-1:0] cp, input logic [2:0] nb,
			input logic [1:0] k);
		logic [7:0] b;
		b = {1'b0, cp[6:0]};
		case (nb)
			3'd2: begin
				b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			end
			3'd3: begin
				case (k)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			3'd4: begin
				case (k)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: b = {1'b0, cp[6:0]};
		endcase
		return b;
	endfunction

endpackage

// ===== design/utt_front.sv =====
// ---------------------------------------------------------------------------
// utt_front
// Takes code units, pairs surrogates and turns them into encode jobs; a held high surrogate makes no job of its own.
// ---------------------------------------------------------------------------
module utt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_ready,
	input  logic [15:0]   code_unit,
	input  logic          text_end,
	output logic          push,
	output utt_pkg::job_t job
);
	import utt_pkg::*;

	logic       pending_q;
	logic [9:0] high_bits_q;
	logic       is_high;
	logic       is_low;
	logic       accept;

	assign is_high = (code_unit[15:10] == HIGH_PREFIX);
	assign is_low  = (code_unit[15:10] == LOW_PREFIX);
	assign accept  = in_valid && in_ready;

	always_comb begin
		job = '0;
		job.pre_fffd = pending_q && !is_low;
		if (pending_q && is_low) begin
			job.cp_valid = 1'b1;
			job.cp = SUPP_BASE + {1'b0, high_bits_q, code_unit[9:0]};
		end else if (is_high) begin
			// held unless the string ends here
			job.cp_valid = text_end;
			job.cp = REPLACEMENT_CP;
		end else if (is_low) begin
			job.cp_valid = 1'b1;
			job.cp = REPLACEMENT_CP;
		end else begin
			job.cp_valid = 1'b1;
			job.cp = {5'd0, code_unit};
		end
		job.nb = utt_len(job.cp);
	end

	assign push = accept && (job.pre_fffd || job.cp_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (accept) begin
			pending_q <= is_high && !text_end;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_high) begin
			high_bits_q <= code_unit[9:0];
		end
	end

endmodule

// ===== design/utt_fifo.sv =====
// ---------------------------------------------------------------------------
// utt_fifo
// Short job queue between the front and the byte sequencer.
// ---------------------------------------------------------------------------
module utt_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  utt_pkg::job_t wr_job,
	output logic          full,
	input  logic          pop,
	output logic          rd_valid,
	output utt_pkg::job_t rd_job
);
	import utt_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX   = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == FULL_COUNT);
	assign rd_valid = (count_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// ===== design/utt_back.sv =====
// ---------------------------------------------------------------------------
// utt_back
// Steps through the bytes of each job into the output register.
// ---------------------------------------------------------------------------
module utt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  utt_pkg::job_t job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    utf8_byte,
	output logic          run_last
);
	import utt_pkg::*;

	`include "utf16_to_utf8_transcoder_top_macros.svh"

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [2:0] total;
	logic [2:0] off;
	logic       load;
	logic       at_end;
	logic [7:0] next_byte;

	assign total  = (job.pre_fffd ? REPL_LEN : 3'd0) + (job.cp_valid ? job.nb : 3'd0);
	assign off    = idx_q - (job.pre_fffd ? REPL_LEN : 3'd0);
	assign load   = job_valid && (!valid_q || out_ready);
	assign at_end = (idx_q == total - 3'd1);
	assign pop    = load && at_end;

	always_comb begin
		if (job.pre_fffd && (idx_q < REPL_LEN)) begin
			next_byte = utt_byte(REPLACEMENT_CP, REPL_LEN, idx_q[1:0]);
		end else begin
			next_byte = utt_byte(job.cp, job.nb, off[1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= at_end ? 3'd0 : idx_q + 3'd1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= next_byte;
			last_q <= at_end;
		end
	end

	assign out_valid = valid_q;
	assign utf8_byte = byte_q;
	assign run_last  = last_q;

	`UTT_ASSERT_NOW(a_idx_in_job, job_valid, idx_q < total, "byte index past end of job")
	`UTT_ASSERT_NOW(a_job_nonempty, job_valid, job.pre_fffd || job.cp_valid, "empty job queued")
	`UTT_ASSERT_NEXT(a_idx_restart, pop, idx_q == 3'd0, "byte index not cleared after job")
	`UTT_ASSERT_NEXT(a_last_marks_pop, load && at_end, valid_q && last_q, "last byte not flagged")

endmodule

// ===== design/utf16_to_utf8_transcoder_top.sv =====
// ---------------------------------------------------------------------------
// utf16_to_utf8_transcoder_top
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing.
// ---------------------------------------------------------------------------
// One code unit is taken per cycle while the job queue has room; bytes leave
// at one per cycle while m_tready is high, from a single output register; a unit
// yields 1 to 4 bytes, up to 6 after an unpaired high surrogate (U+FFFD first).
// A held high surrogate produces no bytes until the next unit. m_tlast marks
// the last byte caused by an input transfer. The byte sequencer and its
// output register set the sustained rate; the queue of QUEUE_DEPTH jobs lets
// input keep flowing while a multi-byte sequence drains.
module utf16_to_utf8_transcoder_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] code_unit
	input  logic        s_tlast,   // text_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] utf8_byte
	output logic        m_tlast    // run_last
);
	import utt_pkg::*;

	job_t wr_job;
	job_t rd_job;
	logic push;
	logic full;
	logic pop;
	logic rd_valid;

	assign s_tready = !full;

	utt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.code_unit (s_tdata),
		.text_end  (s_tlast),
		.push      (push),
		.job       (wr_job)
	);

	utt_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (wr_job),
		.full     (full),
		.pop      (pop),
		.rd_valid (rd_valid),
		.rd_job   (rd_job)
	);

	utt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (rd_valid),
		.job       (rd_job),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.utf8_byte (m_tdata),
		.run_last  (m_tlast)
	);

endmodule
